// File: src/mesh_edge_adjacency_macros.svh
// Assertion shorthands shared by the checker files.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef MESH_EDGE_ADJACENCY_MACROS_SVH
`define MESH_EDGE_ADJACENCY_MACROS_SVH

// Same-cycle implication.
`define MEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mea_pkg.sv
`default_nettype none

package mea_pkg;

  localparam int unsigned MAX_TRIANGLES_DEF = 4096;
  localparam int unsigned TABLE_SLOTS_DEF   = 16384;
  localparam int unsigned VERTEX_BITS_DEF   = 16;

  localparam int unsigned CFG_W       = 15;
  localparam int unsigned IN_VERTEX_W = 16;
  localparam int unsigned TRI_OUT_W   = 12;
  localparam int unsigned EDGE_W      = 2;
  localparam int unsigned NUM_EDGES   = 3;
  localparam int unsigned LINK_CNT_W  = 2;

  // key = lo * KEY_SCALE + hi, KEY_SCALE < 2**KEY_SCALE_W
  localparam int unsigned KEY_SCALE   = 1000000;
  localparam int unsigned KEY_SCALE_W = 20;

  // hash = key[30:0], padded to whole radix-4 digits
  localparam int unsigned HASH_W    = 31;
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned MOD_STEPS = DIV_W / 2;
  localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

  localparam int unsigned MIN_CAPACITY = 16;

  // slot is in use when its epoch equals the current one; epoch 0 marks unused
  localparam int unsigned EPOCH_W = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_MOD,
    ST_HOLD,
    ST_READ,
    ST_CHECK
  } state_e;

endpackage

`default_nettype wire

// File: src/mesh_edge_adjacency.sv
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_stall_o   new_mesh_i, vertex_a_i, vertex_b_i, vertex_c_i
// out       out  out_valid_o / out_stall_i this_triangle_o, this_edge_o, other_triangle_o,
//                                          other_edge_o, run_last_o
// cfg       in   cfg_we_i                  cfg_wdata_i (table_capacity)
//
// Sequence from a beat to the next beat taken: the idle state taking it, a key multiply,
//   16 radix-4 remainder steps (three lanes, one per edge), a hand-off, read + check per
//   edge; each extra probe adds a read + check. Beats past MAX_TRIANGLES are dropped.
// Reset: clearing pass over all TABLE_SLOTS; it reruns on every 255th new mesh (epoch wrap).
// Stalls: links of one triangle drain from a 3-entry link buffer while the next
//   triangle already computes its keys; its probes wait until the buffer is empty.
`default_nettype none

module mesh_edge_adjacency #(
  parameter int unsigned MAX_TRIANGLES = mea_pkg::MAX_TRIANGLES_DEF,
  parameter int unsigned TABLE_SLOTS   = mea_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned VERTEX_BITS   = mea_pkg::VERTEX_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [mea_pkg::CFG_W-1:0]          cfg_wdata_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               new_mesh_i,
  input  wire logic [mea_pkg::IN_VERTEX_W-1:0]    vertex_a_i,
  input  wire logic [mea_pkg::IN_VERTEX_W-1:0]    vertex_b_i,
  input  wire logic [mea_pkg::IN_VERTEX_W-1:0]    vertex_c_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [mea_pkg::TRI_OUT_W-1:0]           this_triangle_o,
  output logic [mea_pkg::EDGE_W-1:0]              this_edge_o,
  output logic [mea_pkg::TRI_OUT_W-1:0]           other_triangle_o,
  output logic [mea_pkg::EDGE_W-1:0]              other_edge_o,
  output logic                                    run_last_o
);

  localparam int unsigned NE     = mea_pkg::NUM_EDGES;
  localparam int unsigned EW     = mea_pkg::EDGE_W;
  localparam int unsigned TOW    = mea_pkg::TRI_OUT_W;
  localparam int unsigned LCW    = mea_pkg::LINK_CNT_W;
  localparam int unsigned TC_W   = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned TRI_W  = $clog2(MAX_TRIANGLES);
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CAP_W  = ($clog2(TABLE_SLOTS + 1) > mea_pkg::CFG_W) ?
                                   $clog2(TABLE_SLOTS + 1) : mea_pkg::CFG_W;
  localparam int unsigned KEY_W  = VERTEX_BITS + mea_pkg::KEY_SCALE_W;
  localparam int unsigned EP_W   = mea_pkg::EPOCH_W;
  localparam int unsigned DIV_W  = mea_pkg::DIV_W;

  // slot layout: {epoch, key, triangle, edge}
  localparam int unsigned EDGE_LSB = 0;
  localparam int unsigned TRI_LSB  = EDGE_LSB + EW;
  localparam int unsigned KEY_LSB  = TRI_LSB + TRI_W;
  localparam int unsigned EP_LSB   = KEY_LSB + KEY_W;
  localparam int unsigned ENT_W    = EP_LSB + EP_W;

  // ---------------------------------------------------------------------------
  // Capacity register, stored already clamped to [MIN_CAPACITY, TABLE_SLOTS]
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CAP_W+1:0] cap2_q, cap3_q;
  logic [CAP_W-1:0] cfg_ext;

  always_comb begin
    cfg_ext = CAP_W'(cfg_wdata_i);
    priority if (cfg_ext < CAP_W'(mea_pkg::MIN_CAPACITY)) begin
      cap_d = CAP_W'(mea_pkg::MIN_CAPACITY);
    end else if (cfg_ext > CAP_W'(TABLE_SLOTS)) begin
      cap_d = CAP_W'(TABLE_SLOTS);
    end else begin
      cap_d = cfg_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(TABLE_SLOTS);
      cap2_q <= (CAP_W + 2)'(TABLE_SLOTS) << 1;
      cap3_q <= ((CAP_W + 2)'(TABLE_SLOTS) << 1) + (CAP_W + 2)'(TABLE_SLOTS);
    end else if (cfg_we_i) begin
      cap_q  <= cap_d;
      cap2_q <= {cap_d, 1'b0} + (CAP_W + 2)'(0);
      cap3_q <= {1'b0, cap_d, 1'b0} + {2'b00, cap_d};
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  mea_pkg::state_e state_q, state_d;

  logic [EP_W-1:0]        epoch_q, epoch_d;
  logic [SLOT_W-1:0]      clr_addr_q, clr_addr_d;
  logic                   item_pend_q, item_pend_d;
  logic [TC_W-1:0]        tri_cnt_q, tri_cnt_d;
  logic [TRI_W-1:0]       tri_q, tri_d;
  logic [mea_pkg::STEP_W-1:0] step_q, step_d;
  logic [EW-1:0]          edge_q, edge_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [CAP_W-1:0]       probe_q, probe_d;

  logic [VERTEX_BITS-1:0] vtx_q [NE];
  logic [VERTEX_BITS-1:0] vtx_d [NE];
  logic [KEY_W-1:0]       key_q [NE];
  logic [KEY_W-1:0]       key_d [NE];
  logic [DIV_W-1:0]       div_q [NE];
  logic [DIV_W-1:0]       div_d [NE];
  logic [CAP_W-1:0]       rem_q [NE];
  logic [CAP_W-1:0]       rem_d [NE];

  // link buffer, drained by the output side
  logic [EW-1:0]          lk_edge_q  [NE];
  logic [EW-1:0]          lk_edge_d  [NE];
  logic [TOW-1:0]         lk_otri_q  [NE];
  logic [TOW-1:0]         lk_otri_d  [NE];
  logic [EW-1:0]          lk_oedge_q [NE];
  logic [EW-1:0]          lk_oedge_d [NE];
  logic [LCW-1:0]         lk_cnt_q, lk_cnt_d;
  logic [TOW-1:0]         out_tri_q, out_tri_d;
  logic                   out_busy_q, out_busy_d;
  logic [LCW-1:0]         out_sel_q, out_sel_d;

  // ---------------------------------------------------------------------------
  // Edge table: one synchronous RAM, read data registered
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0]  edge_table_q [TABLE_SLOTS];
  logic [ENT_W-1:0]  rd_data_q;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0]  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_table_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= edge_table_q[mem_raddr];
    end
  end

  logic [EP_W-1:0]      rd_epoch;
  logic [KEY_W-1:0]     rd_key;
  logic [TRI_W-1:0]     rd_tri;
  logic [EW-1:0]        rd_edge;
  logic [TRI_W+TOW-1:0] rd_tri_wide;
  logic [TRI_W+TOW-1:0] tri_wide;

  assign rd_epoch    = rd_data_q[EP_LSB +: EP_W];
  assign rd_key      = rd_data_q[KEY_LSB +: KEY_W];
  assign rd_tri      = rd_data_q[TRI_LSB +: TRI_W];
  assign rd_edge     = rd_data_q[EDGE_LSB +: EW];
  assign rd_tri_wide = {{TOW{1'b0}}, rd_tri};
  assign tri_wide    = {{TOW{1'b0}}, tri_q};

  // ---------------------------------------------------------------------------
  // Lane logic: inputs masked to VERTEX_BITS, edge keys, radix-4 remainder step
  // ---------------------------------------------------------------------------
  logic [VERTEX_BITS+mea_pkg::IN_VERTEX_W-1:0] vin_wide [NE];
  logic [VERTEX_BITS-1:0] lo_v [NE];
  logic [VERTEX_BITS-1:0] hi_v [NE];
  logic [KEY_W-1:0]       key_calc [NE];
  logic [KEY_W+DIV_W-1:0] key_pad  [NE];
  logic [CAP_W+1:0]       mod_t [NE];
  logic [CAP_W-1:0]       mod_r [NE];

  always_comb begin
    vin_wide[0] = {{VERTEX_BITS{1'b0}}, vertex_a_i};
    vin_wide[1] = {{VERTEX_BITS{1'b0}}, vertex_b_i};
    vin_wide[2] = {{VERTEX_BITS{1'b0}}, vertex_c_i};
  end

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      // edge e joins vertex e and vertex (e+1) mod 3
      if (vtx_q[e] < vtx_q[(e + 1) % NE]) begin
        lo_v[e] = vtx_q[e];
        hi_v[e] = vtx_q[(e + 1) % NE];
      end else begin
        lo_v[e] = vtx_q[(e + 1) % NE];
        hi_v[e] = vtx_q[e];
      end
      key_calc[e] = KEY_W'(lo_v[e]) * KEY_W'(mea_pkg::KEY_SCALE) + KEY_W'(hi_v[e]);
      key_pad[e]  = {{DIV_W{1'b0}}, key_calc[e]};
    end
  end

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      mod_t[e] = {rem_q[e], div_q[e][DIV_W-1 -: 2]};
      priority if (mod_t[e] >= cap3_q) begin
        mod_r[e] = CAP_W'(mod_t[e] - cap3_q);
      end else if (mod_t[e] >= cap2_q) begin
        mod_r[e] = CAP_W'(mod_t[e] - cap2_q);
      end else if (mod_t[e] >= {2'b00, cap_q}) begin
        mod_r[e] = CAP_W'(mod_t[e] - {2'b00, cap_q});
      end else begin
        mod_r[e] = mod_t[e][CAP_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [TC_W-1:0]  cnt_now;
  logic             epoch_wrap;
  logic             edge_done;
  logic [EW-1:0]    edge_nxt;
  logic [CAP_W-1:0] idx_inc;
  logic [SLOT_W-1:0] idx_nxt;

  assign edge_nxt = edge_q + EW'(1);
  assign idx_inc  = CAP_W'(idx_q) + CAP_W'(1);
  assign idx_nxt  = (idx_inc == cap_q) ? '0 : idx_inc[SLOT_W-1:0];

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    clr_addr_d  = clr_addr_q;
    item_pend_d = item_pend_q;
    tri_cnt_d   = tri_cnt_q;
    tri_d       = tri_q;
    step_d      = step_q;
    edge_d      = edge_q;
    idx_d       = idx_q;
    probe_d     = probe_q;
    vtx_d       = vtx_q;
    key_d       = key_q;
    div_d       = div_q;
    rem_d       = rem_q;
    lk_edge_d   = lk_edge_q;
    lk_otri_d   = lk_otri_q;
    lk_oedge_d  = lk_oedge_q;
    lk_cnt_d    = lk_cnt_q;
    out_tri_d   = out_tri_q;
    out_busy_d  = out_busy_q;
    out_sel_d   = out_sel_q;
    cnt_now     = new_mesh_i ? '0 : tri_cnt_q;
    epoch_wrap  = (epoch_q == {EP_W{1'b1}});
    edge_done   = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {epoch_q, key_q[edge_q], tri_q, edge_q};
    mem_re    = 1'b0;
    mem_raddr = idx_q;

    // output side: step through the buffered links
    if (out_busy_q && !out_stall_i) begin
      if (out_sel_q == lk_cnt_q - LCW'(1)) begin
        out_busy_d = 1'b0;
      end else begin
        out_sel_d = out_sel_q + LCW'(1);
      end
    end

    unique case (state_q)
      mea_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + SLOT_W'(1);
        if (clr_addr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          clr_addr_d = '0;
          state_d    = item_pend_q ? mea_pkg::ST_KEY : mea_pkg::ST_IDLE;
        end
      end

      mea_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          for (int e = 0; e < NE; e++) begin
            vtx_d[e] = vin_wide[e][VERTEX_BITS-1:0];
          end
          if (new_mesh_i) begin
            tri_cnt_d = '0;
            epoch_d   = epoch_wrap ? EP_W'(1) : epoch_q + EP_W'(1);
          end
          if (cnt_now < TC_W'(MAX_TRIANGLES)) begin
            tri_d       = cnt_now[TRI_W-1:0];
            tri_cnt_d   = cnt_now + TC_W'(1);
            item_pend_d = 1'b1;
            state_d     = mea_pkg::ST_KEY;
          end
          if (new_mesh_i && epoch_wrap) begin
            state_d = mea_pkg::ST_CLEAR;
          end
        end
      end

      mea_pkg::ST_KEY: begin
        for (int e = 0; e < NE; e++) begin
          key_d[e] = key_calc[e];
          div_d[e] = {1'b0, key_pad[e][mea_pkg::HASH_W-1:0]};
          rem_d[e] = '0;
        end
        step_d  = '0;
        state_d = mea_pkg::ST_MOD;
      end

      mea_pkg::ST_MOD: begin
        for (int e = 0; e < NE; e++) begin
          rem_d[e] = mod_r[e];
          div_d[e] = div_q[e] << 2;
        end
        step_d = step_q + mea_pkg::STEP_W'(1);
        if (step_q == mea_pkg::STEP_W'(mea_pkg::MOD_STEPS - 1)) begin
          state_d = mea_pkg::ST_HOLD;
        end
      end

      mea_pkg::ST_HOLD: begin
        // link buffer must be drained before this triangle fills it
        if (!out_busy_q) begin
          edge_d   = '0;
          lk_cnt_d = '0;
          idx_d    = rem_q[0][SLOT_W-1:0];
          probe_d  = '0;
          state_d  = mea_pkg::ST_READ;
        end
      end

      mea_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = mea_pkg::ST_CHECK;
      end

      mea_pkg::ST_CHECK: begin
        priority if (rd_epoch != epoch_q) begin
          // empty slot: claim it
          mem_we    = 1'b1;
          edge_done = 1'b1;
        end else if (rd_key == key_q[edge_q]) begin
          lk_edge_d[lk_cnt_q]  = edge_q;
          lk_otri_d[lk_cnt_q]  = rd_tri_wide[TOW-1:0];
          lk_oedge_d[lk_cnt_q] = rd_edge;
          lk_cnt_d             = lk_cnt_q + LCW'(1);
          edge_done            = 1'b1;
        end else if (probe_q == cap_q - CAP_W'(1)) begin
          // whole table probed: drop this edge
          edge_done = 1'b1;
        end else begin
          idx_d     = idx_nxt;
          probe_d   = probe_q + CAP_W'(1);
          mem_re    = 1'b1;
          mem_raddr = idx_nxt;
        end

        if (edge_done) begin
          if (edge_q == EW'(NE - 1)) begin
            item_pend_d = 1'b0;
            out_tri_d   = tri_wide[TOW-1:0];
            state_d     = mea_pkg::ST_IDLE;
            if (lk_cnt_d != '0) begin
              out_busy_d = 1'b1;
              out_sel_d  = '0;
            end
          end else begin
            edge_d  = edge_nxt;
            idx_d   = rem_q[edge_nxt][SLOT_W-1:0];
            probe_d = '0;
            state_d = mea_pkg::ST_READ;
          end
        end
      end

      default: begin
        state_d = mea_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mea_pkg::ST_CLEAR;
      epoch_q     <= EP_W'(1);
      clr_addr_q  <= '0;
      item_pend_q <= 1'b0;
      tri_cnt_q   <= '0;
      step_q      <= '0;
      edge_q      <= '0;
      probe_q     <= '0;
      lk_cnt_q    <= '0;
      out_busy_q  <= 1'b0;
      out_sel_q   <= '0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      clr_addr_q  <= clr_addr_d;
      item_pend_q <= item_pend_d;
      tri_cnt_q   <= tri_cnt_d;
      step_q      <= step_d;
      edge_q      <= edge_d;
      probe_q     <= probe_d;
      lk_cnt_q    <= lk_cnt_d;
      out_busy_q  <= out_busy_d;
      out_sel_q   <= out_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q      <= tri_d;
    idx_q      <= idx_d;
    vtx_q      <= vtx_d;
    key_q      <= key_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    lk_edge_q  <= lk_edge_d;
    lk_otri_q  <= lk_otri_d;
    lk_oedge_q <= lk_oedge_d;
    out_tri_q  <= out_tri_d;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign in_stall_o       = (state_q != mea_pkg::ST_IDLE);
  assign out_valid_o      = out_busy_q;
  assign this_triangle_o  = out_tri_q;
  assign this_edge_o      = lk_edge_q[out_sel_q];
  assign other_triangle_o = lk_otri_q[out_sel_q];
  assign other_edge_o     = lk_oedge_q[out_sel_q];
  assign run_last_o       = (out_sel_q == lk_cnt_q - LCW'(1));

endmodule

`default_nettype wire

// File: src/mesh_edge_adjacency_checker.sv
`default_nettype none
`include "mesh_edge_adjacency_macros.svh"

module mesh_edge_adjacency_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [mea_pkg::TRI_OUT_W-1:0] this_triangle_o,
  input wire logic [mea_pkg::EDGE_W-1:0]    this_edge_o,
  input wire logic [mea_pkg::TRI_OUT_W-1:0] other_triangle_o,
  input wire logic [mea_pkg::EDGE_W-1:0]    other_edge_o,
  input wire logic                          run_last_o
);

  // stalled beat holds
  `MEA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(this_triangle_o) && $stable(this_edge_o) && $stable(other_triangle_o) && $stable(other_edge_o) && $stable(run_last_o), "out beat changed while stalled")

  // edge numbers stay within a triangle
  `MEA_ASSERT_NOW(a_edge_range, out_valid_o, (this_edge_o < mea_pkg::EDGE_W'(mea_pkg::NUM_EDGES)) && (other_edge_o < mea_pkg::EDGE_W'(mea_pkg::NUM_EDGES)), "edge number out of range")

  // a run does not break before its last link
  `MEA_ASSERT_NEXT(a_run_cont, out_valid_o && !out_stall_i && !run_last_o, out_valid_o, "link run ended without run_last")

  // links of one triangle come in rising edge order
  `MEA_ASSERT_NEXT(a_run_order, out_valid_o && !out_stall_i && !run_last_o, (this_edge_o > $past(this_edge_o)) && (this_triangle_o == $past(this_triangle_o)), "link run out of order")

endmodule

bind mesh_edge_adjacency mesh_edge_adjacency_checker u_checker (.*);

`default_nettype wire
